>>> rtl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared constants and payload types of the GPIO pin register block.
// ----------------------------------------------------------------------------
package gpr_pkg;

  localparam int unsigned PIN_COUNT_DEF = 54;
  localparam int unsigned MAX_PINS      = 64;
  localparam int unsigned HALF_BITS     = 32;
  localparam int unsigned HIGH_W        = 22;

  // function select layout
  localparam int unsigned FSEL_WORDS   = 6;
  localparam int unsigned FSEL_FIELDS  = 10;
  localparam int unsigned FSEL_FIELD_W = 3;
  localparam int unsigned FSEL_BITS    = FSEL_FIELDS * FSEL_FIELD_W;
  localparam int unsigned FSEL_IDX_W   = $clog2(FSEL_WORDS);

  // register word offsets
  localparam logic [5:0] WORD_FSEL_END  = 6'd6;
  localparam logic [5:0] WORD_SET_LO    = 6'd7;
  localparam logic [5:0] WORD_SET_HI    = 6'd8;
  localparam logic [5:0] WORD_CLR_LO    = 6'd10;
  localparam logic [5:0] WORD_CLR_HI    = 6'd11;
  localparam logic [5:0] WORD_LEV_LO    = 6'd13;
  localparam logic [5:0] WORD_LEV_HI    = 6'd14;
  localparam logic [5:0] WORD_PUD       = 6'd37;
  localparam logic [5:0] WORD_PUDCLK_LO = 6'd38;
  localparam logic [5:0] WORD_PUDCLK_HI = 6'd39;

  // access kind
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // field codes
  localparam logic [2:0] FUNC_OUTPUT = 3'd1;
  localparam logic [1:0] PULL_OFF    = 2'd0;
  localparam logic [1:0] PULL_DOWN   = 2'd1;
  localparam logic [1:0] PULL_UP     = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [5:0]        word_index;
    logic [31:0]       write_data;
    logic [31:0]       pads_low;
    logic [HIGH_W-1:0] pads_high;
  } req_t;

  typedef struct packed {
    logic [31:0]       read_data;
    logic [31:0]       drive_low;
    logic [HIGH_W-1:0] drive_high;
    logic [31:0]       enable_low;
    logic [HIGH_W-1:0] enable_high;
    logic [31:0]       pullup_low;
    logic [HIGH_W-1:0] pullup_high;
    logic [31:0]       pulldown_low;
    logic [HIGH_W-1:0] pulldown_high;
  } rsp_t;

endpackage

>>> rtl/gpr_if.sv
// ----------------------------------------------------------------------------
// gpr_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface gpr_req_if;
  import gpr_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gpr_rsp_if;
  import gpr_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/gpio_pin_register_block.sv
// ----------------------------------------------------------------------------
// gpio_pin_register_block
// GPIO register file: function selects, set/clear output latch, pad levels
// and pull control, one bus access per transfer.
// Each access is registered in the input register, then the result register;
// throughput: one access per cycle while the result side does not stall,
// set by the single decode and update pass between the two registers.
// Reset clears both stage valids and all pin state (inputs, latch low,
// pulls off); no clearing pass, the block accepts right after reset.
// ----------------------------------------------------------------------------
module gpio_pin_register_block #(
  parameter int unsigned PIN_COUNT = gpr_pkg::PIN_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gpr_req_if.sink       req_i,
  gpr_rsp_if.source     rsp_o
);
  import gpr_pkg::*;

  localparam logic [MAX_PINS-1:0] PIN_MASK = {MAX_PINS{1'b1}} >> (MAX_PINS - PIN_COUNT);
  localparam logic [31:0] HALF_MASK_LO = PIN_MASK[31:0];
  localparam logic [31:0] HALF_MASK_HI = PIN_MASK[63:32];

  // input stage
  req_t s1_q;
  logic s1_valid_q;

  // result stage
  rsp_t rsp_q;
  logic rsp_valid_q;
  logic rsp_mode_q;

  // pin state
  logic [FSEL_WORDS-1:0][FSEL_BITS-1:0] fsel_q, fsel_d;
  logic [FSEL_WORDS-1:0][FSEL_BITS-1:0] fsel_mask;
  logic [PIN_COUNT-1:0]                 latch_q;
  logic [MAX_PINS-1:0]                  latch_d;
  logic [1:0]                           pctl_q, pctl_d;
  logic [1:0][31:0]                     pclk_q, pclk_d;
  logic [1:0]                           pull_q [PIN_COUNT];
  logic [1:0]                           pull_d [PIN_COUNT];

  logic                advance;
  logic                accept;
  logic                wr;
  logic [5:0]          idx;
  logic [31:0]         wdata;
  logic [31:0]         rd;
  logic [MAX_PINS-1:0] pads;
  logic [MAX_PINS-1:0] pclk_set;
  logic [MAX_PINS-1:0] en, up, dn;
  rsp_t                rsp_d;

  assign advance     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  assign wr    = (s1_q.mode == MODE_WRITE);
  assign idx   = s1_q.word_index;
  assign wdata = s1_q.write_data;
  assign pads  = MAX_PINS'({s1_q.pads_high, s1_q.pads_low}) & PIN_MASK;

  // keep only fields of pins that exist
  for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_fmask
    for (genvar k = 0; k < FSEL_FIELDS; k++) begin : g_field
      assign fsel_mask[w][k*FSEL_FIELD_W +: FSEL_FIELD_W] =
        (w * FSEL_FIELDS + k < PIN_COUNT) ? {FSEL_FIELD_W{1'b1}} : '0;
    end
  end

  always_comb begin
    fsel_d   = fsel_q;
    latch_d  = MAX_PINS'(latch_q);
    pctl_d   = pctl_q;
    pclk_d   = pclk_q;
    pclk_set = '0;
    rd       = '0;
    case (idx)
      WORD_SET_LO: begin
        if (wr) latch_d = latch_d | MAX_PINS'(wdata & HALF_MASK_LO);
      end
      WORD_SET_HI: begin
        if (wr) latch_d = latch_d | {wdata & HALF_MASK_HI, 32'b0};
      end
      WORD_CLR_LO: begin
        if (wr) latch_d = latch_d & ~MAX_PINS'(wdata & HALF_MASK_LO);
      end
      WORD_CLR_HI: begin
        if (wr) latch_d = latch_d & ~{wdata & HALF_MASK_HI, 32'b0};
      end
      WORD_LEV_LO: begin
        rd = pads[31:0];
      end
      WORD_LEV_HI: begin
        rd = pads[63:32];
      end
      WORD_PUD: begin
        if (wr) pctl_d = wdata[1:0];
        else    rd = {30'b0, pctl_q};
      end
      WORD_PUDCLK_LO: begin
        if (wr) begin
          pclk_d[0] = wdata & HALF_MASK_LO;
          pclk_set  = MAX_PINS'(wdata & HALF_MASK_LO);
        end else begin
          rd = pclk_q[0];
        end
      end
      WORD_PUDCLK_HI: begin
        if (wr) begin
          pclk_d[1] = wdata & HALF_MASK_HI;
          pclk_set  = {wdata & HALF_MASK_HI, 32'b0};
        end else begin
          rd = pclk_q[1];
        end
      end
      default: begin
        if (idx < WORD_FSEL_END) begin
          if (wr) begin
            fsel_d[idx[FSEL_IDX_W-1:0]] =
              wdata[FSEL_BITS-1:0] & fsel_mask[idx[FSEL_IDX_W-1:0]];
          end else begin
            rd = 32'(fsel_q[idx[FSEL_IDX_W-1:0]]);
          end
        end
      end
    endcase
  end

  // pull clock latches the current control value (not the one written now)
  always_comb begin
    for (int q = 0; q < PIN_COUNT; q++) begin
      pull_d[q] = pclk_set[q] ? pctl_q : pull_q[q];
    end
  end

  // status reflects state after the access
  for (genvar p = 0; p < MAX_PINS; p++) begin : g_status
    if (p < PIN_COUNT && p < FSEL_WORDS * FSEL_FIELDS) begin : g_fsel
      assign en[p] = (fsel_d[p / FSEL_FIELDS][(p % FSEL_FIELDS) * FSEL_FIELD_W +:
                      FSEL_FIELD_W] == FUNC_OUTPUT);
    end else begin : g_nofsel
      assign en[p] = 1'b0;
    end
    if (p < PIN_COUNT) begin : g_pull
      assign up[p] = (pull_d[p] == PULL_UP);
      assign dn[p] = (pull_d[p] == PULL_DOWN);
    end else begin : g_nopull
      assign up[p] = 1'b0;
      assign dn[p] = 1'b0;
    end
  end

  always_comb begin
    rsp_d.read_data     = wr ? '0 : rd;
    rsp_d.drive_low     = latch_d[31:0];
    rsp_d.drive_high    = latch_d[HALF_BITS +: HIGH_W];
    rsp_d.enable_low    = en[31:0];
    rsp_d.enable_high   = en[HALF_BITS +: HIGH_W];
    rsp_d.pullup_low    = up[31:0];
    rsp_d.pullup_high   = up[HALF_BITS +: HIGH_W];
    rsp_d.pulldown_low  = dn[31:0];
    rsp_d.pulldown_high = dn[HALF_BITS +: HIGH_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept)       s1_valid_q <= 1'b1;
      else if (advance) s1_valid_q <= 1'b0;
      if (advance)           rsp_valid_q <= 1'b1;
      else if (rsp_o.ready)  rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= req_i.data;
    if (advance) begin
      rsp_q      <= rsp_d;
      rsp_mode_q <= s1_q.mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q  <= '0;
      latch_q <= '0;
      pctl_q  <= PULL_OFF;
      pclk_q  <= '0;
      for (int q = 0; q < PIN_COUNT; q++) pull_q[q] <= PULL_OFF;
    end else if (advance) begin
      fsel_q  <= fsel_d;
      latch_q <= PIN_COUNT'(latch_d);
      pctl_q  <= pctl_d;
      pclk_q  <= pclk_d;
      for (int q = 0; q < PIN_COUNT; q++) pull_q[q] <= pull_d[q];
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

`ifndef SYNTHESIS
  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_mode_q == MODE_WRITE) |-> (rsp_q.read_data == '0))
    else $error("write transfer returned nonzero read data");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && rsp_valid_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("input taken while input stage is stuck");

  a_pull_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> ((rsp_q.pullup_low & rsp_q.pulldown_low) == '0 &&
                     (rsp_q.pullup_high & rsp_q.pulldown_high) == '0))
    else $error("pin shows pull up and pull down at once");

  a_result_follows_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> rsp_valid_q)
    else $error("advanced item produced no result");
`endif

endmodule

>>> sim/gpio_pin_register_block_tb.sv
// ----------------------------------------------------------------------------
// gpio_pin_register_block_tb
// Self-checking bench for the GPIO register block. Bus accesses go in over
// the request channel. A shadow copy of the pin state predicts every result.
// Each result is checked field by field, in order. Random gaps and stalls
// are used on both channels, with one long result hold-off that fills the
// pipeline.
// ----------------------------------------------------------------------------
module gpio_pin_register_block_tb;
  import gpr_pkg::*;

  localparam int          PINS         = PIN_COUNT_DEF;
  localparam logic [63:0] PIN_MASK     = (64'd1 << PINS) - 64'd1;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_ITEMS = 1950;
  localparam int          DRAIN_CYCLES = 10;
  // every 3-bit field set to the output function
  localparam logic [31:0] FSEL_ALL_OUT = 32'h0924_9249;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] ALT_BITS     = 32'hAAAA_AAAA;
  localparam logic [31:0] LOW_HALF     = 32'h0000_FFFF;

  localparam logic [5:0] WORD_FSEL_FIRST = 6'd0;
  localparam logic [5:0] WORD_FSEL_PIN30 = 6'd3;
  localparam logic [5:0] WORD_FSEL_LAST  = WORD_FSEL_END - 6'd1;
  localparam logic [5:0] WORD_HOLE_SET   = 6'd9;
  localparam logic [5:0] WORD_HOLE_CLR   = 6'd12;
  localparam logic [5:0] WORD_TOP        = 6'd63;

  logic clk_i;
  logic rst_ni;

  gpr_req_if req_bus ();
  gpr_rsp_if rsp_bus ();

  gpio_pin_register_block u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // shadow pin state
  logic [2:0]      pin_fn   [PINS];
  logic [PINS-1:0] out_latch;
  logic [1:0]      pull_ctl;
  logic [31:0]     pull_clk [2];
  logic [1:0]      pull_st  [PINS];

  rsp_t        pending_results[$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned stall_cycles;
  int unsigned cycle_count;
  bit          tx_no_gap;
  bit          rx_no_gap;
  bit          hold_pending;
  int          stall_left;

  function automatic logic [31:0] half_mask(input int unsigned h);
    return PIN_MASK[h*32 +: 32];
  endfunction

  // updates the shadow state and returns the result of one access
  function automatic rsp_t apply_access(input req_t a);
    logic [31:0] rd;
    logic [31:0] msk;
    logic [63:0] pads;
    logic [63:0] lat;
    logic [63:0] en;
    logic [63:0] up;
    logic [63:0] dn;
    int unsigned w;
    int unsigned h;
    int unsigned p;
    bit          wr;
    rsp_t        r;
    rd   = '0;
    en   = '0;
    up   = '0;
    dn   = '0;
    pads = {10'd0, a.pads_high, a.pads_low} & PIN_MASK;
    lat  = 64'(out_latch);
    wr   = (a.mode == MODE_WRITE);
    w    = 32'(a.word_index);
    if (w < WORD_FSEL_END) begin
      for (int k = 0; k < FSEL_FIELDS; k++) begin
        p = w * FSEL_FIELDS + k;
        if (p < PINS) begin
          if (wr) pin_fn[p] = a.write_data[3*k +: 3];
          else rd[3*k +: 3] = pin_fn[p];
        end
      end
    end else if (w == WORD_SET_LO || w == WORD_SET_HI) begin
      h = (w == WORD_SET_HI) ? 1 : 0;
      if (wr) lat |= 64'(a.write_data & half_mask(h)) << (h * 32);
    end else if (w == WORD_CLR_LO || w == WORD_CLR_HI) begin
      h = (w == WORD_CLR_HI) ? 1 : 0;
      if (wr) lat &= ~(64'(a.write_data & half_mask(h)) << (h * 32));
    end else if (w == WORD_LEV_LO || w == WORD_LEV_HI) begin
      h = (w == WORD_LEV_HI) ? 1 : 0;
      if (!wr) rd = pads[h*32 +: 32];
    end else if (w == WORD_PUD) begin
      if (wr) pull_ctl = a.write_data[1:0];
      else rd = {30'd0, pull_ctl};
    end else if (w == WORD_PUDCLK_LO || w == WORD_PUDCLK_HI) begin
      h = (w == WORD_PUDCLK_HI) ? 1 : 0;
      if (wr) begin
        msk = a.write_data & half_mask(h);
        pull_clk[h] = msk;
        for (int b = 0; b < 32; b++) begin
          p = h * 32 + b;
          if (msk[b] && p < PINS) pull_st[p] = pull_ctl;
        end
      end else begin
        rd = pull_clk[h];
      end
    end
    out_latch = lat[PINS-1:0];
    lat = 64'(out_latch);
    for (int q = 0; q < PINS; q++) begin
      en[q] = (pin_fn[q] == FUNC_OUTPUT);
      up[q] = (pull_st[q] == PULL_UP);
      dn[q] = (pull_st[q] == PULL_DOWN);
    end
    r.read_data     = wr ? 32'd0 : rd;
    r.drive_low     = lat[31:0];
    r.drive_high    = lat[53:32];
    r.enable_low    = en[31:0];
    r.enable_high   = en[53:32];
    r.pullup_low    = up[31:0];
    r.pullup_high   = up[53:32];
    r.pulldown_low  = dn[31:0];
    r.pulldown_high = dn[53:32];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_no_gap || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [5:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 6'($urandom_range(0, FSEL_WORDS - 1));
      1: return $urandom_range(0, 1) ? WORD_SET_HI : WORD_SET_LO;
      2: return $urandom_range(0, 1) ? WORD_CLR_HI : WORD_CLR_LO;
      3: return $urandom_range(0, 1) ? WORD_LEV_HI : WORD_LEV_LO;
      4: return WORD_PUD;
      5: return $urandom_range(0, 1) ? WORD_PUDCLK_HI : WORD_PUDCLK_LO;
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return FSEL_ALL_OUT & $urandom();
      4: return 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_access(input logic mode, input logic [5:0] word,
                             input logic [31:0] data, input logic [31:0] pl,
                             input logic [HIGH_W-1:0] ph);
    req_t item;
    int   gap;
    item.mode       = mode;
    item.word_index = word;
    item.write_data = data;
    item.pads_low   = pl;
    item.pads_high  = ph;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.data  <= item;
    do @(posedge clk_i); while (!req_bus.ready);
    pending_results.push_back(apply_access(item));
    sent_count++;
  endtask

  task automatic access(input logic mode, input logic [5:0] word, input logic [31:0] data);
    send_access(mode, word, data, $urandom(), HIGH_W'($urandom()));
  endtask

  task automatic random_access();
    access(logic'($urandom_range(0, 1)), pick_word(), rand_data());
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic test_function_select();
    access(MODE_WRITE, WORD_FSEL_FIRST, ALL_ONES);
    access(MODE_READ,  WORD_FSEL_FIRST, '0);
    access(MODE_WRITE, WORD_FSEL_LAST,  ALL_ONES);
    access(MODE_READ,  WORD_FSEL_LAST,  '0);
    access(MODE_WRITE, WORD_FSEL_PIN30, FSEL_ALL_OUT);
    access(MODE_READ,  WORD_FSEL_PIN30, '0);
  endtask

  task automatic test_output_latch();
    access(MODE_WRITE, WORD_SET_LO, ALL_ONES);
    access(MODE_WRITE, WORD_SET_HI, ALL_ONES);
    access(MODE_READ,  WORD_SET_LO, '0);
    access(MODE_WRITE, WORD_CLR_LO, ALT_BITS);
    access(MODE_WRITE, WORD_CLR_HI, ALL_ONES);
  endtask

  task automatic test_pad_levels();
    send_access(MODE_READ,  WORD_LEV_LO, '0, ALL_ONES, '1);
    send_access(MODE_READ,  WORD_LEV_HI, '0, ALL_ONES, '1);
    send_access(MODE_WRITE, WORD_LEV_LO, ALL_ONES, ALL_ONES, '1);
  endtask

  task automatic test_pull_control();
    // value 3 is kept as written and latches as neither up nor down
    access(MODE_WRITE, WORD_PUD,       ALL_ONES);
    access(MODE_READ,  WORD_PUD,       '0);
    access(MODE_WRITE, WORD_PUDCLK_LO, ALL_ONES);
    access(MODE_WRITE, WORD_PUD,       32'(PULL_UP));
    access(MODE_WRITE, WORD_PUDCLK_HI, ALL_ONES);
    access(MODE_READ,  WORD_PUDCLK_HI, '0);
    access(MODE_WRITE, WORD_PUD,       32'(PULL_DOWN));
    access(MODE_WRITE, WORD_PUDCLK_LO, LOW_HALF);
    access(MODE_READ,  WORD_PUDCLK_LO, '0);
  endtask

  task automatic test_unmapped();
    access(MODE_WRITE, WORD_FSEL_END, ALL_ONES);
    access(MODE_READ,  WORD_HOLE_SET, '0);
    access(MODE_WRITE, WORD_HOLE_CLR, ALL_ONES);
    access(MODE_READ,  WORD_TOP,      '0);
  endtask

  // long result hold-off while requests keep coming back to back
  task automatic test_backpressure();
    hold_pending = 1'b1;
    tx_no_gap    = 1'b1;
    repeat (24) random_access();
    tx_no_gap    = 1'b0;
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      tx_no_gap = (n >= 600 && n < 900);
      rx_no_gap = tx_no_gap;
      if ($urandom_range(0, 4) == 0) begin
        // pull programming: control value, then a clock word
        access(MODE_WRITE, WORD_PUD, $urandom());
        access(MODE_WRITE, $urandom_range(0, 1) ? WORD_PUDCLK_HI : WORD_PUDCLK_LO,
               rand_data());
        n += 2;
      end else begin
        random_access();
        n++;
      end
    end
    tx_no_gap = 1'b0;
    rx_no_gap = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // result side ready, with random stalls and the requested hold-off
  initial begin
    rsp_bus.ready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        stall_left   = HOLD_CYCLES - 1;
        rsp_bus.ready <= 1'b0;
      end else if (!rx_no_gap && $urandom_range(0, 99) < 20) begin
        stall_left = stall_len() - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && !req_bus.ready) stall_cycles++;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no access outstanding");
          error_count++;
        end else begin
          rsp_t exp_r;
          exp_r = pending_results.pop_front();
          check_field("read_data",     exp_r.read_data,     rsp_bus.data.read_data);
          check_field("drive_low",     exp_r.drive_low,     rsp_bus.data.drive_low);
          check_field("drive_high",    32'(exp_r.drive_high),
                      32'(rsp_bus.data.drive_high));
          check_field("enable_low",    exp_r.enable_low,    rsp_bus.data.enable_low);
          check_field("enable_high",   32'(exp_r.enable_high),
                      32'(rsp_bus.data.enable_high));
          check_field("pullup_low",    exp_r.pullup_low,    rsp_bus.data.pullup_low);
          check_field("pullup_high",   32'(exp_r.pullup_high),
                      32'(rsp_bus.data.pullup_high));
          check_field("pulldown_low",  exp_r.pulldown_low,  rsp_bus.data.pulldown_low);
          check_field("pulldown_high", 32'(exp_r.pulldown_high),
                      32'(rsp_bus.data.pulldown_high));
          checked_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.data  = '0;
    error_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    stall_cycles  = 0;
    out_latch     = '0;
    pull_ctl      = PULL_OFF;
    pull_clk[0]   = '0;
    pull_clk[1]   = '0;
    for (int i = 0; i < PINS; i++) begin
      pin_fn[i]  = '0;
      pull_st[i] = PULL_OFF;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_function_select();
    test_output_latch();
    test_pad_levels();
    test_pull_control();
    test_unmapped();
    test_backpressure();
    test_random();

    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d accesses (function select, set/clear, pads, pull, unmapped),",
             sent_count);
    $display("checked %0d results, request side stalled for %0d cycles",
             checked_count, stall_cycles);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
